// ----- sv/quaternion_arith_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit assertion macros
// Clocked property shorthands with reset qualification.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_ARITH_UNIT_ASSERT_SVH
`define QUATERNION_ARITH_UNIT_ASSERT_SVH

// same-cycle implication
`define QAU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("quaternion_arith_unit: assertion failed");

// next-cycle implication
`define QAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("quaternion_arith_unit: assertion failed");

`endif

// ----- sv/qau_pkg.sv -----
// ----------------------------------------------------------------------------
// qau_pkg
// Types, widths and rounding helpers of the quaternion arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package qau_pkg;

    localparam int Q_W    = 16;
    localparam int Q_FRAC = 14;
    localparam int P_W    = 2 * Q_W;          // 16x16 product
    localparam int H_W    = P_W + 3;          // sum of four products
    localparam int M_W    = P_W + 2;          // rotation matrix element
    localparam int MP_W   = Q_W + M_W;        // vector by element product
    localparam int R_W    = MP_W + 2;         // rotation row sum

    typedef logic signed [Q_W-1:0] t_q14;

    typedef struct packed {
        t_q14 w;
        t_q14 x;
        t_q14 y;
        t_q14 z;
    } t_quat;

    typedef struct packed {
        t_q14 x;
        t_q14 y;
        t_q14 z;
    } t_vec;

    typedef enum logic [1:0] {
        OP_MUL  = 2'd0,
        OP_ROT  = 2'd1,
        OP_CONJ = 2'd2
    } t_op;

    localparam t_q14 Q_MAX = 16'sh7fff;
    localparam t_q14 Q_MIN = 16'sh8000;

    localparam logic signed [R_W-1:0] SAT_HI = R_W'(Q_MAX);
    localparam logic signed [R_W-1:0] SAT_LO = R_W'(Q_MIN);

    // round to nearest (ties up), then saturate to Q2.14
    function automatic t_q14 f_round_sat(input logic signed [R_W-1:0] v,
                                         input int unsigned s);
        logic signed [R_W-1:0] half;
        logic signed [R_W-1:0] t;
        half = R_W'(1) << (s - 1);
        t    = (v + half) >>> s;
        if (t > SAT_HI) begin
            return Q_MAX;
        end else if (t < SAT_LO) begin
            return Q_MIN;
        end
        return t[Q_W-1:0];
    endfunction

    function automatic t_q14 f_neg_sat(input t_q14 v);
        return (v == Q_MIN) ? Q_MAX : -v;
    endfunction

endpackage

`default_nettype wire

// ----- sv/qau_in_if.sv -----
// ----------------------------------------------------------------------------
// qau_in_if
// Operation word channel: opcode and two quaternions.
// ----------------------------------------------------------------------------
`default_nettype none

interface qau_in_if;
    import qau_pkg::*;

    logic       valid;
    logic       ready;
    logic [1:0] op;
    t_q14       qa_w;
    t_q14       qa_x;
    t_q14       qa_y;
    t_q14       qa_z;
    t_q14       qb_w;
    t_q14       qb_x;
    t_q14       qb_y;
    t_q14       qb_z;

    modport source (
        output valid, op, qa_w, qa_x, qa_y, qa_z, qb_w, qb_x, qb_y, qb_z,
        input  ready
    );

    modport sink (
        input  valid, op, qa_w, qa_x, qa_y, qa_z, qb_w, qb_x, qb_y, qb_z,
        output ready
    );
endinterface

`default_nettype wire

// ----- sv/qau_out_if.sv -----
// ----------------------------------------------------------------------------
// qau_out_if
// Result word channel: one Q2.14 quaternion.
// ----------------------------------------------------------------------------
`default_nettype none

interface qau_out_if;
    import qau_pkg::*;

    logic valid;
    logic ready;
    t_q14 res_w;
    t_q14 res_x;
    t_q14 res_y;
    t_q14 res_z;

    modport source (
        output valid, res_w, res_x, res_y, res_z,
        input  ready
    );

    modport sink (
        input  valid, res_w, res_x, res_y, res_z,
        output ready
    );
endinterface

`default_nettype wire

// ----- sv/quaternion_arith_unit.sv -----
// ----------------------------------------------------------------------------
// quaternion_arith_unit
// Q2.14 quaternion unit: Hamilton product, vector rotation, conjugate.
//
//   port    dir  payload                         handshake
//   i_in    in   op, qa_w..qa_z, qb_w..qb_z      valid / ready
//   o_res   out  res_w, res_x, res_y, res_z      valid / ready
//
// One word per cycle sustained while the output is not stalled.
// Four register stages: products, sums or matrix, rotate products, output.
// All stages advance together whenever the output register is empty or
// being taken; a stall freezes the whole pipeline.
// Reset clears the stage valid bits only.
// ----------------------------------------------------------------------------
`default_nettype none
`include "quaternion_arith_unit_assert.svh"

module quaternion_arith_unit (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    qau_in_if.sink    i_in,
    qau_out_if.source o_res
);
    import qau_pkg::*;

    localparam int unsigned HP_SH = Q_FRAC;

    logic w_en;

    logic r_v1, r_v2, r_v3, r_v4;
    t_op  r_op1, r_op2, r_op3;

    t_q14 w_a [4];
    t_q14 w_b [4];

    logic signed [P_W-1:0] r_hp1 [4][4];
    logic signed [H_W-1:0] r_hs2 [4];
    t_quat                 r_hr3;
    t_quat                 r_cj1, r_cj2, r_cj3;

    t_quat w_qa;
    t_vec  w_vec;
    t_vec  w_rot;

    t_quat n_res;
    t_quat r_res4;

    assign w_en       = !r_v4 || o_res.ready;
    assign i_in.ready = w_en;

    assign w_a[0] = i_in.qa_w;
    assign w_a[1] = i_in.qa_x;
    assign w_a[2] = i_in.qa_y;
    assign w_a[3] = i_in.qa_z;
    assign w_b[0] = i_in.qb_w;
    assign w_b[1] = i_in.qb_x;
    assign w_b[2] = i_in.qb_y;
    assign w_b[3] = i_in.qb_z;

    assign w_qa  = '{w: i_in.qa_w, x: i_in.qa_x, y: i_in.qa_y, z: i_in.qa_z};
    assign w_vec = '{x: i_in.qb_x, y: i_in.qb_y, z: i_in.qb_z};

    qau_rot u_rot (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_qa  (w_qa),
        .i_vec (w_vec),
        .o_vec (w_rot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_in.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // stage 1: all sixteen cross products, conjugate
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    r_hp1[i][j] <= P_W'(w_a[i]) * P_W'(w_b[j]);
                end
            end
            r_op1   <= t_op'(i_in.op);
            r_cj1.w <= i_in.qa_w;
            r_cj1.x <= f_neg_sat(i_in.qa_x);
            r_cj1.y <= f_neg_sat(i_in.qa_y);
            r_cj1.z <= f_neg_sat(i_in.qa_z);
        end
    end

    // stage 2: Hamilton sums (index 0 w, 1 x, 2 y, 3 z)
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hs2[0] <= H_W'(r_hp1[0][0]) - H_W'(r_hp1[1][1])
                      - H_W'(r_hp1[2][2]) - H_W'(r_hp1[3][3]);
            r_hs2[1] <= H_W'(r_hp1[0][1]) + H_W'(r_hp1[1][0])
                      + H_W'(r_hp1[2][3]) - H_W'(r_hp1[3][2]);
            r_hs2[2] <= H_W'(r_hp1[0][2]) + H_W'(r_hp1[2][0])
                      + H_W'(r_hp1[3][1]) - H_W'(r_hp1[1][3]);
            r_hs2[3] <= H_W'(r_hp1[0][3]) + H_W'(r_hp1[3][0])
                      + H_W'(r_hp1[1][2]) - H_W'(r_hp1[2][1]);
            r_op2    <= r_op1;
            r_cj2    <= r_cj1;
        end
    end

    // stage 3: round and saturate the product
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hr3.w <= f_round_sat(R_W'(r_hs2[0]), HP_SH);
            r_hr3.x <= f_round_sat(R_W'(r_hs2[1]), HP_SH);
            r_hr3.y <= f_round_sat(R_W'(r_hs2[2]), HP_SH);
            r_hr3.z <= f_round_sat(R_W'(r_hs2[3]), HP_SH);
            r_op3   <= r_op2;
            r_cj3   <= r_cj2;
        end
    end

    always_comb begin
        case (r_op3)
            OP_MUL: begin
                n_res = r_hr3;
            end
            OP_ROT: begin
                n_res = '{w: '0, x: w_rot.x, y: w_rot.y, z: w_rot.z};
            end
            OP_CONJ: begin
                n_res = r_cj3;
            end
            default: begin
                n_res = '0;
            end
        endcase
    end

    // stage 4: output register
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_res4 <= n_res;
        end
    end

    assign o_res.valid = r_v4;
    assign o_res.res_w = r_res4.w;
    assign o_res.res_x = r_res4.x;
    assign o_res.res_y = r_res4.y;
    assign o_res.res_z = r_res4.z;

    `QAU_ASSERT_SAME(a_ready_when_empty, i_clk, i_rst_n, !r_v4, i_in.ready)
    `QAU_ASSERT_NEXT(a_valid_advance, i_clk, i_rst_n, w_en && r_v3, o_res.valid)
    `QAU_ASSERT_NEXT(a_rot_w_zero, i_clk, i_rst_n, w_en && r_v3 && (r_op3 == OP_ROT), o_res.res_w == '0)
    `QAU_ASSERT_NEXT(a_unused_op_zero, i_clk, i_rst_n, w_en && r_v3 && (r_op3 != OP_MUL) && (r_op3 != OP_ROT) && (r_op3 != OP_CONJ), (o_res.res_w == '0) && (o_res.res_x == '0) && (o_res.res_y == '0) && (o_res.res_z == '0))

endmodule

`default_nettype wire

// ----- sv/qau_rot.sv -----
// ----------------------------------------------------------------------------
// qau_rot
// Three-stage vector rotation: quaternion products, matrix elements,
// vector-by-element products; row sums are rounded at the output.
// ----------------------------------------------------------------------------
`default_nettype none

module qau_rot (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire qau_pkg::t_quat i_qa,
    input  wire qau_pkg::t_vec  i_vec,
    output qau_pkg::t_vec       o_vec
);
    import qau_pkg::*;

    localparam logic signed [M_W-1:0] ROT_ONE = M_W'(1) << (2 * Q_FRAC);
    localparam int unsigned           ROT_SH  = 2 * Q_FRAC;

    // stage 1 products
    logic signed [P_W-1:0] r_xx, r_yy, r_zz, r_xy, r_wz, r_zx, r_wy, r_yz, r_wx;
    t_vec                  r_vec1;
    // stage 2 matrix
    logic signed [M_W-1:0] r_m2 [3][3];
    t_vec                  r_vec2;
    // stage 3 products
    logic signed [MP_W-1:0] r_mp3 [3][3];

    t_q14 w_v2 [3];
    t_q14 n_row [3];

    function automatic logic signed [M_W-1:0] f_dbl(input logic signed [P_W-1:0] p);
        return M_W'(p) <<< 1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xx   <= P_W'(i_qa.x) * P_W'(i_qa.x);
            r_yy   <= P_W'(i_qa.y) * P_W'(i_qa.y);
            r_zz   <= P_W'(i_qa.z) * P_W'(i_qa.z);
            r_xy   <= P_W'(i_qa.x) * P_W'(i_qa.y);
            r_wz   <= P_W'(i_qa.w) * P_W'(i_qa.z);
            r_zx   <= P_W'(i_qa.z) * P_W'(i_qa.x);
            r_wy   <= P_W'(i_qa.w) * P_W'(i_qa.y);
            r_yz   <= P_W'(i_qa.y) * P_W'(i_qa.z);
            r_wx   <= P_W'(i_qa.w) * P_W'(i_qa.x);
            r_vec1 <= i_vec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m2[0][0] <= ROT_ONE - f_dbl(r_yy) - f_dbl(r_zz);
            r_m2[0][1] <= f_dbl(r_xy) - f_dbl(r_wz);
            r_m2[0][2] <= f_dbl(r_zx) + f_dbl(r_wy);
            r_m2[1][0] <= f_dbl(r_xy) + f_dbl(r_wz);
            r_m2[1][1] <= ROT_ONE - f_dbl(r_zz) - f_dbl(r_xx);
            r_m2[1][2] <= f_dbl(r_yz) - f_dbl(r_wx);
            r_m2[2][0] <= f_dbl(r_zx) - f_dbl(r_wy);
            r_m2[2][1] <= f_dbl(r_yz) + f_dbl(r_wx);
            r_m2[2][2] <= ROT_ONE - f_dbl(r_xx) - f_dbl(r_yy);
            r_vec2     <= r_vec1;
        end
    end

    assign w_v2[0] = r_vec2.x;
    assign w_v2[1] = r_vec2.y;
    assign w_v2[2] = r_vec2.z;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_mp3[i][j] <= MP_W'(w_v2[j]) * MP_W'(r_m2[i][j]);
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_row[i] = f_round_sat(R_W'(r_mp3[i][0]) + R_W'(r_mp3[i][1])
                                   + R_W'(r_mp3[i][2]), ROT_SH);
        end
    end

    assign o_vec = '{x: n_row[0], y: n_row[1], z: n_row[2]};

endmodule

`default_nettype wire
